[rtl/lrsr_pkg.sv]
package lrsr_pkg;

    localparam int unsigned STATE_W      = 8;
    localparam int unsigned SYM_W        = 6;
    localparam int unsigned RULE_W       = 8;
    localparam int unsigned LEN_W        = 4;
    localparam int unsigned DEPTH_W      = 9;
    localparam int unsigned ENTRY_W      = 10;
    localparam int unsigned CNT_W        = 7;
    localparam int unsigned ACTION_DEPTH = 16384;
    localparam int unsigned RULE_DEPTH   = 256;
    localparam int unsigned STACK_DEPTH  = 256;
    localparam int unsigned CHAIN_LIMIT  = 62;
    localparam int unsigned RECOV_LIMIT  = 63;

    typedef enum logic [1:0] {
        FUNC_TOKEN  = 2'd0,
        FUNC_ACTION = 2'd1,
        FUNC_RULE   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ACT_ERROR  = 2'd0,
        ACT_SHIFT  = 2'd1,
        ACT_REDUCE = 2'd2,
        ACT_ACCEPT = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        K_SHIFTED   = 3'd0,
        K_REDUCED   = 3'd1,
        K_ACCEPTED  = 3'd2,
        K_DISCARDED = 3'd3,
        K_REPORTED  = 3'd4,
        K_FAILED    = 3'd5,
        K_ACK       = 3'd6,
        K_OVERFLOW  = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        FIN_NONE     = 2'd0,
        FIN_ACCEPTED = 2'd1,
        FIN_FAILED   = 2'd2
    } fin_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACT_RD,
        S_ACT,
        S_TOP_RD,
        S_RULE_RD,
        S_RULE,
        S_POP_RD,
        S_GOTO_RD,
        S_GOTO,
        S_FAIL
    } state_t;

    localparam logic [2:0] ADDR_ERROR_SYM = 3'd0;
    localparam logic [2:0] ADDR_END_SYM   = 3'd4;

endpackage

[rtl/lr_shift_reduce_parse_engine_unit.sv]
// Table writes and clears: one result each.
// Token: a lookup reads, then acts; a recovery pop adds a stack top reload, a reduce a
// rule read, stack top reload and goto lookup; each action waits on one memory read.
// Results leave through an output register; the engine stalls only when it is full.
// Reset clears stack pointer, repair and finished status and the output valid flag;
// action, rule and stack memories hold undefined data until written.
module lr_shift_reduce_parse_engine_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [5:0]  symbol,
    input  logic [7:0]  row_state,
    input  logic [1:0]  entry_kind,
    input  logic [7:0]  entry_target,
    input  logic [7:0]  rule_index,
    input  logic [3:0]  rule_length,
    input  logic [5:0]  rule_head,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  rule_number,
    output logic [7:0]  top_state,
    output logic [8:0]  depth,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned SW = lrsr_pkg::STATE_W;
    localparam int unsigned YW = lrsr_pkg::SYM_W;
    localparam int unsigned DW = lrsr_pkg::DEPTH_W;
    localparam int unsigned EW = lrsr_pkg::ENTRY_W;
    localparam int unsigned CW = lrsr_pkg::CNT_W;

    logic [EW-1:0] action_mem [lrsr_pkg::ACTION_DEPTH];
    logic [EW-1:0] rule_mem   [lrsr_pkg::RULE_DEPTH];
    logic [SW-1:0] stack_mem  [lrsr_pkg::STACK_DEPTH];

    lrsr_pkg::state_t state_reg, state_next;
    lrsr_pkg::fin_t   fin_reg, fin_next;
    lrsr_pkg::kind_t  fail_kind_reg, fail_kind_next;
    logic [DW-1:0]    sp_reg, sp_next;
    logic [SW-1:0]    top_reg, top_next;
    logic             repair_reg, repair_next;
    logic             rec_reg, rec_next;
    logic [YW-1:0]    sym_reg, sym_next;
    logic [SW-1:0]    rule_reg, rule_next;
    logic [YW-1:0]    head_reg, head_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [YW-1:0]    err_sym_reg, end_sym_reg;

    logic             out_valid_reg, out_valid_next;
    lrsr_pkg::kind_t  out_kind_reg, out_kind_next;
    logic [SW-1:0]    out_rule_reg, out_rule_next;
    logic [SW-1:0]    out_top_reg, out_top_next;
    logic [DW-1:0]    out_depth_reg, out_depth_next;
    logic             out_last_reg, out_last_next;

    logic [EW-1:0]    act_q, rule_q;
    logic [SW-1:0]    stack_q;
    logic             act_re, rule_re, stack_re, stack_we, act_we, rule_we;
    logic [13:0]      act_raddr;
    logic [SW-1:0]    stack_raddr, stack_wdata;

    logic             can_emit, accept, stack_full, sym_is_end;
    lrsr_pkg::act_t   act_kind;
    logic [SW-1:0]    act_tgt;
    logic [YW-1:0]    look_sym;
    logic [DW-1:0]    pop_sp;
    logic [lrsr_pkg::LEN_W-1:0] r_len;

    assign can_emit   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == lrsr_pkg::S_IDLE) && can_emit;
    assign accept     = in_valid && in_ready;
    assign stack_full = sp_reg >= DW'(lrsr_pkg::STACK_DEPTH);
    assign act_kind   = lrsr_pkg::act_t'(act_q[EW-1:SW]);
    assign act_tgt    = act_q[SW-1:0];
    assign look_sym   = rec_reg ? err_sym_reg : sym_reg;
    assign sym_is_end = sym_reg == end_sym_reg;
    assign r_len      = rule_q[EW-1:YW];
    assign pop_sp     = (DW'(r_len) > sp_reg) ? '0 : sp_reg - DW'(r_len);
    assign act_we     = accept && (lrsr_pkg::func_t'(func) == lrsr_pkg::FUNC_ACTION);
    assign rule_we    = accept && (lrsr_pkg::func_t'(func) == lrsr_pkg::FUNC_RULE);

    // configuration port
    assign pready = 1'b1;
    always_comb
    begin
        case (paddr)
            lrsr_pkg::ADDR_ERROR_SYM: prdata = {26'd0, err_sym_reg};
            lrsr_pkg::ADDR_END_SYM:   prdata = {26'd0, end_sym_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_sym_reg <= YW'(1);
            end_sym_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == lrsr_pkg::ADDR_ERROR_SYM)
                err_sym_reg <= pwdata[YW-1:0];
            if (paddr == lrsr_pkg::ADDR_END_SYM)
                end_sym_reg <= pwdata[YW-1:0];
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (act_we)
            action_mem[{row_state, symbol}] <= {entry_kind, entry_target};
        if (act_re)
            act_q <= action_mem[act_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rule_we)
            rule_mem[rule_index] <= {rule_length, rule_head};
        if (rule_re)
            rule_q <= rule_mem[rule_reg];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[sp_reg[SW-1:0]] <= stack_wdata;
        if (stack_re)
            stack_q <= stack_mem[stack_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lrsr_pkg::S_IDLE:
                if (accept && lrsr_pkg::func_t'(func) == lrsr_pkg::FUNC_TOKEN
                    && fin_reg == lrsr_pkg::FIN_NONE)
                    state_next = lrsr_pkg::S_ACT_RD;
            lrsr_pkg::S_ACT_RD:
                if (rec_reg ? (sp_reg == '0 || cnt_reg >= CW'(lrsr_pkg::RECOV_LIMIT))
                            : (cnt_reg >= CW'(lrsr_pkg::CHAIN_LIMIT)))
                    state_next = lrsr_pkg::S_FAIL;
                else
                    state_next = lrsr_pkg::S_ACT;
            lrsr_pkg::S_ACT:
                unique case (act_kind)
                    lrsr_pkg::ACT_SHIFT:
                        if (stack_full)
                            state_next = lrsr_pkg::S_FAIL;
                        else if (can_emit)
                            state_next = rec_reg ? lrsr_pkg::S_ACT_RD : lrsr_pkg::S_IDLE;
                    lrsr_pkg::ACT_REDUCE:
                        state_next = lrsr_pkg::S_RULE_RD;
                    lrsr_pkg::ACT_ACCEPT:
                        if (rec_reg)
                            state_next = lrsr_pkg::S_FAIL;
                        else if (can_emit)
                            state_next = lrsr_pkg::S_IDLE;
                    default:
                        if (rec_reg)
                            state_next = (sp_reg == DW'(1)) ? lrsr_pkg::S_ACT_RD
                                                            : lrsr_pkg::S_TOP_RD;
                        else if (can_emit)
                        begin
                            if (repair_reg)
                                state_next = sym_is_end ? lrsr_pkg::S_FAIL
                                                        : lrsr_pkg::S_IDLE;
                            else
                                state_next = lrsr_pkg::S_ACT_RD;
                        end
                endcase
            lrsr_pkg::S_TOP_RD:
                state_next = lrsr_pkg::S_ACT_RD;
            lrsr_pkg::S_RULE_RD:
                state_next = lrsr_pkg::S_RULE;
            lrsr_pkg::S_RULE:
                state_next = (pop_sp == '0) ? lrsr_pkg::S_GOTO_RD : lrsr_pkg::S_POP_RD;
            lrsr_pkg::S_POP_RD:
                state_next = lrsr_pkg::S_GOTO_RD;
            lrsr_pkg::S_GOTO_RD:
                state_next = lrsr_pkg::S_GOTO;
            lrsr_pkg::S_GOTO:
                if (stack_full)
                    state_next = lrsr_pkg::S_FAIL;
                else if (can_emit)
                    state_next = lrsr_pkg::S_ACT_RD;
            lrsr_pkg::S_FAIL:
                if (can_emit)
                    state_next = lrsr_pkg::S_IDLE;
            default:
                state_next = lrsr_pkg::S_IDLE;
        endcase
    end

    // datapath and result control
    always_comb
    begin
        logic             emit;
        lrsr_pkg::kind_t  e_kind;
        logic             e_last;
        logic [SW-1:0]    e_rule;

        emit           = 1'b0;
        e_kind         = lrsr_pkg::K_ACK;
        e_last         = 1'b0;
        e_rule         = '0;
        fin_next       = fin_reg;
        fail_kind_next = fail_kind_reg;
        sp_next        = sp_reg;
        top_next       = top_reg;
        repair_next    = repair_reg;
        rec_next       = rec_reg;
        sym_next       = sym_reg;
        rule_next      = rule_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        act_re         = 1'b0;
        act_raddr      = {top_reg, look_sym};
        rule_re        = 1'b0;
        stack_re       = 1'b0;
        stack_raddr    = sp_reg[SW-1:0] - SW'(1);
        stack_we       = 1'b0;
        stack_wdata    = act_tgt;

        unique case (state_reg)
            lrsr_pkg::S_IDLE:
                if (accept)
                begin
                    cnt_next = '0;
                    rec_next = 1'b0;
                    sym_next = symbol;
                    case (lrsr_pkg::func_t'(func))
                        lrsr_pkg::FUNC_TOKEN:
                            if (fin_reg != lrsr_pkg::FIN_NONE)
                            begin
                                emit   = 1'b1;
                                e_kind = lrsr_pkg::K_DISCARDED;
                                e_last = 1'b1;
                            end
                            else if (sp_reg == '0)
                            begin
                                stack_we    = 1'b1;
                                stack_wdata = '0;
                                sp_next     = DW'(1);
                                top_next    = '0;
                            end
                        lrsr_pkg::FUNC_CLEAR:
                        begin
                            sp_next     = '0;
                            top_next    = '0;
                            repair_next = 1'b0;
                            fin_next    = lrsr_pkg::FIN_NONE;
                            emit        = 1'b1;
                            e_last      = 1'b1;
                        end
                        default:
                        begin
                            emit   = 1'b1;
                            e_last = 1'b1;
                        end
                    endcase
                end
            lrsr_pkg::S_ACT_RD:
            begin
                act_re         = 1'b1;
                fail_kind_next = lrsr_pkg::K_FAILED;
            end
            lrsr_pkg::S_ACT:
                unique case (act_kind)
                    lrsr_pkg::ACT_SHIFT:
                        if (stack_full)
                            fail_kind_next = lrsr_pkg::K_OVERFLOW;
                        else if (can_emit)
                        begin
                            stack_we    = 1'b1;
                            sp_next     = sp_reg + DW'(1);
                            top_next    = act_tgt;
                            repair_next = rec_reg;
                            rec_next    = 1'b0;
                            emit        = 1'b1;
                            e_kind      = lrsr_pkg::K_SHIFTED;
                            e_last      = !rec_reg;
                        end
                    lrsr_pkg::ACT_REDUCE:
                        rule_next = act_tgt;
                    lrsr_pkg::ACT_ACCEPT:
                        if (!rec_reg && can_emit)
                        begin
                            repair_next = 1'b0;
                            fin_next    = lrsr_pkg::FIN_ACCEPTED;
                            emit        = 1'b1;
                            e_kind      = lrsr_pkg::K_ACCEPTED;
                            e_last      = 1'b1;
                        end
                    default:
                        if (rec_reg)
                        begin
                            // drop one state and reload the new top
                            sp_next     = sp_reg - DW'(1);
                            stack_re    = 1'b1;
                            stack_raddr = sp_reg[SW-1:0] - SW'(2);
                            if (sp_reg == DW'(1))
                                top_next = '0;
                        end
                        else if (can_emit)
                        begin
                            emit = 1'b1;
                            if (repair_reg)
                            begin
                                e_kind = sym_is_end ? lrsr_pkg::K_REPORTED
                                                    : lrsr_pkg::K_DISCARDED;
                                e_last = !sym_is_end;
                            end
                            else
                            begin
                                e_kind   = lrsr_pkg::K_REPORTED;
                                rec_next = 1'b1;
                            end
                        end
                endcase
            lrsr_pkg::S_TOP_RD:
                top_next = stack_q;
            lrsr_pkg::S_RULE_RD:
                rule_re = 1'b1;
            lrsr_pkg::S_RULE:
            begin
                head_next   = rule_q[YW-1:0];
                sp_next     = pop_sp;
                stack_re    = 1'b1;
                stack_raddr = pop_sp[SW-1:0] - SW'(1);
                if (pop_sp == '0)
                    top_next = '0;
            end
            lrsr_pkg::S_POP_RD:
                top_next = stack_q;
            lrsr_pkg::S_GOTO_RD:
            begin
                act_re    = 1'b1;
                act_raddr = {top_reg, head_reg};
            end
            lrsr_pkg::S_GOTO:
                if (stack_full)
                    fail_kind_next = lrsr_pkg::K_OVERFLOW;
                else if (can_emit)
                begin
                    stack_we = 1'b1;
                    sp_next  = sp_reg + DW'(1);
                    top_next = act_tgt;
                    emit     = 1'b1;
                    e_kind   = lrsr_pkg::K_REDUCED;
                    e_rule   = rule_reg;
                end
            lrsr_pkg::S_FAIL:
                if (can_emit)
                begin
                    fin_next = lrsr_pkg::FIN_FAILED;
                    rec_next = 1'b0;
                    emit     = 1'b1;
                    e_kind   = fail_kind_reg;
                    e_last   = 1'b1;
                end
            default:
            begin
                rec_next = 1'b0;
            end
        endcase

        if (emit)
            cnt_next = cnt_next + CW'(1);

        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_rule_next  = out_rule_reg;
        out_top_next   = out_top_reg;
        out_depth_next = out_depth_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = e_kind;
            out_rule_next  = e_rule;
            out_top_next   = (sp_next == '0) ? '0 : top_next;
            out_depth_next = sp_next;
            out_last_next  = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrsr_pkg::S_IDLE;
            fin_reg       <= lrsr_pkg::FIN_NONE;
            sp_reg        <= '0;
            top_reg       <= '0;
            repair_reg    <= 1'b0;
            rec_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fin_reg       <= fin_next;
            sp_reg        <= sp_next;
            top_reg       <= top_next;
            repair_reg    <= repair_next;
            rec_reg       <= rec_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fail_kind_reg <= fail_kind_next;
        sym_reg       <= sym_next;
        rule_reg      <= rule_next;
        head_reg      <= head_next;
        out_kind_reg  <= out_kind_next;
        out_rule_reg  <= out_rule_next;
        out_top_reg   <= out_top_next;
        out_depth_reg <= out_depth_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign rule_number = out_rule_reg;
    assign top_state   = out_top_reg;
    assign depth       = out_depth_reg;
    assign last        = out_last_reg;

endmodule

[tb/sv/lrsr_checker.sv]
`timescale 1ns / 1ps

module lrsr_checker
    import lrsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  func,
    input  logic [5:0]  symbol,
    input  logic [7:0]  row_state,
    input  logic [1:0]  entry_kind,
    input  logic [7:0]  entry_target,
    input  logic [7:0]  rule_index,
    input  logic [3:0]  rule_length,
    input  logic [5:0]  rule_head,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  kind,
    input  logic [7:0]  rule_number,
    input  logic [7:0]  top_state,
    input  logic [8:0]  depth,
    input  logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    typedef struct {
        kind_t      kind;
        logic [7:0] rule;
        logic [7:0] top;
        logic [8:0] dep;
        logic       lst;
    } parse_result_t;

    logic [9:0]    action_mem [ACTION_DEPTH];
    logic [9:0]    rule_mem [RULE_DEPTH];
    logic [7:0]    state_mem [STACK_DEPTH];
    int            sp;
    bit            repairing;
    fin_t          fin;
    logic [5:0]    err_sym;
    logic [5:0]    end_sym;
    int            step_n;
    parse_result_t parse_q [$];

    assign pending = parse_q.size();

    function automatic logic [7:0] stack_top();
        return (sp != 0) ? state_mem[sp - 1] : 8'd0;
    endfunction

    function automatic void post(kind_t k, logic [7:0] r);
        parse_result_t t;
        t.kind = k;
        t.rule = r;
        t.top  = stack_top();
        t.dep  = sp[8:0];
        t.lst  = 1'b0;
        parse_q.push_back(t);
        step_n++;
    endfunction

    function automatic void fail_out(kind_t k);
        post(k, 8'd0);
        fin = FIN_FAILED;
    endfunction

    function automatic bit push_state(logic [7:0] s);
        if (sp >= STACK_DEPTH)
        begin
            fail_out(K_OVERFLOW);
            return 1'b0;
        end
        state_mem[sp] = s;
        sp++;
        return 1'b1;
    endfunction

    function automatic bit reduce_by(logic [7:0] r);
        int         len;
        logic [5:0] head;
        len  = rule_mem[r][9:6];
        head = rule_mem[r][5:0];
        sp   = (len > sp) ? 0 : sp - len;
        // goto takes the target whatever the entry kind
        if (!push_state(action_mem[{stack_top(), head}][7:0]))
            return 1'b0;
        post(K_REDUCED, r);
        return 1'b1;
    endfunction

    function automatic bit recover_err();
        logic [9:0] a;
        while (sp > 0)
        begin
            if (step_n >= RECOV_LIMIT)
            begin
                fail_out(K_FAILED);
                return 1'b0;
            end
            a = action_mem[{stack_top(), err_sym}];
            case (act_t'(a[9:8]))
                ACT_REDUCE: if (!reduce_by(a[7:0])) return 1'b0;
                ACT_ERROR:  sp--;
                ACT_SHIFT:
                begin
                    if (!push_state(a[7:0]))
                        return 1'b0;
                    repairing = 1'b1;
                    post(K_SHIFTED, 8'd0);
                    return 1'b1;
                end
                default:
                begin
                    fail_out(K_FAILED);
                    return 1'b0;
                end
            endcase
        end
        fail_out(K_FAILED);
        return 1'b0;
    endfunction

    function automatic void parse_token(logic [5:0] sym);
        logic [9:0] a;
        if (fin != FIN_NONE)
        begin
            post(K_DISCARDED, 8'd0);
            return;
        end
        if (sp == 0 && !push_state(8'd0))
            return;
        forever
        begin
            if (step_n >= CHAIN_LIMIT)
            begin
                fail_out(K_FAILED);
                return;
            end
            a = action_mem[{stack_top(), sym}];
            case (act_t'(a[9:8]))
                ACT_SHIFT:
                begin
                    if (!push_state(a[7:0]))
                        return;
                    repairing = 1'b0;
                    post(K_SHIFTED, 8'd0);
                    return;
                end
                ACT_REDUCE: if (!reduce_by(a[7:0])) return;
                ACT_ACCEPT:
                begin
                    repairing = 1'b0;
                    fin = FIN_ACCEPTED;
                    post(K_ACCEPTED, 8'd0);
                    return;
                end
                default:
                begin
                    if (repairing)
                    begin
                        if (sym == end_sym)
                        begin
                            post(K_REPORTED, 8'd0);
                            fail_out(K_FAILED);
                        end
                        else
                            post(K_DISCARDED, 8'd0);
                        return;
                    end
                    post(K_REPORTED, 8'd0);
                    if (!recover_err())
                        return;
                end
            endcase
        end
    endfunction

    function automatic void predict_request();
        step_n = 0;
        case (func_t'(func))
            FUNC_TOKEN:  parse_token(symbol);
            FUNC_ACTION:
            begin
                action_mem[{row_state, symbol}] = {entry_kind, entry_target};
                post(K_ACK, 8'd0);
            end
            FUNC_RULE:
            begin
                rule_mem[rule_index] = {rule_length, rule_head};
                post(K_ACK, 8'd0);
            end
            default:
            begin
                sp        = 0;
                repairing = 1'b0;
                fin       = FIN_NONE;
                post(K_ACK, 8'd0);
            end
        endcase
        parse_q[parse_q.size() - 1].lst = 1'b1;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t e;
        if (!rst_n)
        begin
            sp         = 0;
            repairing  = 1'b0;
            fin        = FIN_NONE;
            err_sym    = 6'd1;
            end_sym    = 6'd0;
            fail_count = 0;
            checked    = 0;
            parse_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_ERROR_SYM)
                    err_sym = pwdata[5:0];
                else if (paddr == ADDR_END_SYM)
                    end_sym = pwdata[5:0];
            end
            if (in_valid && in_ready)
                predict_request();
            if (out_valid && out_ready)
            begin
                checked++;
                if (parse_q.size() == 0)
                begin
                    $error("unexpected result, kind %0d", kind);
                    fail_count++;
                end
                else
                begin
                    e = parse_q.pop_front();
                    check_field("kind", e.kind, kind);
                    check_field("rule_number", e.rule, rule_number);
                    check_field("top_state", e.top, top_state);
                    check_field("depth", e.dep, depth);
                    check_field("last", e.lst, last);
                end
            end
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import lrsr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [5:0]  symbol;
    logic [7:0]  row_state;
    logic [1:0]  entry_kind;
    logic [7:0]  entry_target;
    logic [7:0]  rule_index;
    logic [3:0]  rule_length;
    logic [5:0]  rule_head;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [7:0]  rule_number;
    logic [7:0]  top_state;
    logic [8:0]  depth;
    logic        last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int sent;
    int cyc;
    int idle_in;
    int idle_out;
    bit holding;
    bit hold_go;
    logic [5:0] end_now;

    lr_shift_reduce_parse_engine_unit dut (.*);

    lrsr_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cyc < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cyc++;
        end
        $display("FAIL lr_shift_reduce_parse_engine_unit");
        $finish;
    end

    always @(posedge clk)
        out_ready <= holding ? 1'b0 : ($urandom_range(99) >= idle_out);

    // long receiver hold-off so the engine backs up onto its request side
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        holding <= 1'b1;
        repeat (400) @(posedge clk);
        holding <= 1'b0;
    end

    task automatic send(func_t f, logic [5:0] sym, logic [7:0] row, act_t ek,
                        logic [7:0] tgt, logic [7:0] ridx, logic [3:0] rlen,
                        logic [5:0] rhead);
        if ($urandom_range(99) < idle_in)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        symbol       <= sym;
        row_state    <= row;
        entry_kind   <= ek;
        entry_target <= tgt;
        rule_index   <= ridx;
        rule_length  <= rlen;
        rule_head    <= rhead;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    task automatic token(logic [5:0] sym);
        send(FUNC_TOKEN, sym, $urandom, act_t'($urandom), $urandom, $urandom,
             $urandom, $urandom);
    endtask

    task automatic clear_parse();
        send(FUNC_CLEAR, $urandom, $urandom, act_t'($urandom), $urandom, $urandom,
             $urandom, $urandom);
    endtask

    task automatic act_wr(logic [7:0] row, logic [5:0] sym, act_t ek, logic [7:0] tgt);
        send(FUNC_ACTION, sym, row, ek, tgt, $urandom, $urandom, $urandom);
    endtask

    task automatic rule_wr(logic [7:0] ridx, logic [3:0] rlen, logic [5:0] rhead);
        send(FUNC_RULE, $urandom, $urandom, act_t'($urandom), $urandom, ridx, rlen,
             rhead);
    endtask

    function automatic act_t pick_kind();
        int p;
        p = $urandom_range(99);
        if (p < 20) return ACT_ERROR;
        if (p < 65) return ACT_SHIFT;
        if (p < 95) return ACT_REDUCE;
        return ACT_ACCEPT;
    endfunction

    function automatic logic [3:0] pick_len();
        return ($urandom_range(99) < 90) ? $urandom_range(0, 3) : $urandom_range(0, 15);
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic reg_wr(logic [2:0] addr, logic [5:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= {26'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_phase(int n, bit pressure);
        int p;
        for (int i = 0; i < n; i++)
        begin
            if (pressure && i == 25)
                hold_go = 1'b1;
            p = $urandom_range(99);
            if (p < 75)
                token(($urandom_range(99) < 15) ? end_now : 6'($urandom));
            else if (p < 83)
                act_wr($urandom, $urandom, pick_kind(), $urandom);
            else if (p < 88)
                rule_wr($urandom, $urandom, $urandom);
            else
                clear_parse();
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        func     <= FUNC_TOKEN;
        symbol   <= '0;
        row_state <= '0;
        entry_kind <= ACT_ERROR;
        entry_target <= '0;
        rule_index <= '0;
        rule_length <= '0;
        rule_head <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        holding  <= 1'b0;
        hold_go  = 1'b0;
        idle_in  = 16;
        idle_out = 47;
        end_now  = 6'd0;
        sent     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every table entry gets written so no lookup ever hits stale memory
        for (int r = 0; r < RULE_DEPTH; r++)
            rule_wr(r, pick_len(), $urandom);
        for (int s = 0; s < 256; s++)
            for (int y = 0; y < 64; y++)
                act_wr(s, y, pick_kind(), $urandom);

        // stack overflow: each token after the first walks 50 zero-length reductions then shifts
        rule_wr(8'd0, 4'd0, 6'd10);
        act_wr(8'd0, 6'd2, ACT_SHIFT, 8'd100);
        for (int i = 0; i < 50; i++)
        begin
            act_wr(8'(100 + i), 6'd2, ACT_REDUCE, 8'd0);
            act_wr(8'(100 + i), 6'd10, ACT_SHIFT, 8'(101 + i));
        end
        act_wr(8'd150, 6'd2, ACT_SHIFT, 8'd100);
        // endless reduction loop
        rule_wr(8'd1, 4'd0, 6'd12);
        act_wr(8'd0, 6'd3, ACT_SHIFT, 8'd160);
        act_wr(8'd160, 6'd3, ACT_REDUCE, 8'd1);
        act_wr(8'd160, 6'd12, ACT_SHIFT, 8'd160);
        // error recovery into repair, then end of input
        act_wr(8'd0, 6'd4, ACT_ERROR, 8'd0);
        act_wr(8'd0, 6'd1, ACT_SHIFT, 8'd170);
        act_wr(8'd170, 6'd4, ACT_ERROR, 8'd0);
        act_wr(8'd170, 6'd0, ACT_ERROR, 8'd0);
        // reduce popping past the bottom, goto from state 0, then accept
        rule_wr(8'd2, 4'd15, 6'd11);
        act_wr(8'd0, 6'd5, ACT_REDUCE, 8'd2);
        act_wr(8'd0, 6'd11, ACT_ACCEPT, 8'd171);
        act_wr(8'd171, 6'd5, ACT_ACCEPT, 8'd0);

        clear_parse();
        repeat (7) token(6'd2);
        clear_parse();
        repeat (3) token(6'd3);
        clear_parse();
        token(6'd4);
        token(6'd4);
        token(6'd0);
        token(6'd4);
        clear_parse();
        token(6'd5);
        token(6'd5);
        drain();

        reg_wr(ADDR_ERROR_SYM, 6'd63);
        reg_wr(ADDR_END_SYM, 6'd63);
        end_now = 6'd63;
        random_phase(90, 1'b1);
        drain();

        idle_in  = 47;
        idle_out = 16;
        reg_wr(ADDR_ERROR_SYM, 6'd0);
        reg_wr(ADDR_END_SYM, 6'd62);
        end_now = 6'd62;
        random_phase(85, 1'b0);
        drain();

        idle_in  = 0;
        idle_out = 0;
        end_now  = $urandom;
        reg_wr(ADDR_ERROR_SYM, $urandom);
        reg_wr(ADDR_END_SYM, end_now);
        random_phase(85, 1'b0);
        drain();

        $display("Sent %0d requests (table loads, directed parses, random tokens)", sent);
        $display("Checked %0d results across three stall profiles and four settings",
                 checked);
        if (fail_count == 0 && pending == 0)
            $display("PASS lr_shift_reduce_parse_engine_unit");
        else
            $display("FAIL lr_shift_reduce_parse_engine_unit");
        $finish;
    end

endmodule
